// File: rtl/bm25s_pkg.sv
// shared types, constants and command codes for the bm25 document scorer
package bm25s_pkg;

  // register map
  localparam int          CFG_INDEX_W = 2;
  localparam int          CFG_DATA_W  = 17;
  localparam logic [1:0]  CFG_K1      = 2'd0;
  localparam logic [1:0]  CFG_B       = 2'd1;
  localparam logic [1:0]  CFG_AVG     = 2'd2;

  // register reset values
  localparam logic [15:0] K1_RESET  = 16'd4915;
  localparam logic [16:0] B_RESET   = 17'd49152;
  localparam logic [15:0] AVG_RESET = 16'd1;

  // fixed point anchors
  localparam logic [16:0] B_ONE      = 17'd65536;  // 1.0 in Q1.16
  localparam logic [16:0] K1_ONE     = 17'd4096;   // 1.0 in Q4.12
  localparam logic [15:0] AVG_MIN    = 16'd1;      // 1.0 tokens
  localparam int          DEN_TF_SHIFT = 28;
  localparam int          RATIO_FRAC   = 16;
  localparam int          IDF_FRAC     = 8;
  localparam int          PRODUCT_FRAC = IDF_FRAC + RATIO_FRAC;
  localparam int          SCORE_FRAC_BITS_DEF = 16;

  // datapath widths
  localparam int MA_W     = 33;  // unsigned multiplier operand
  localparam int MB_W     = 18;  // signed multiplier operand
  localparam int PROD_W   = MA_W + 1 + MB_W;
  localparam int NUM_W    = 49;
  localparam int DEN_W    = 61;
  localparam int Q_W      = 32;
  localparam int IDFP_W   = 48;
  localparam int SCORE_W  = 32;

  typedef struct packed {
    logic [31:0]        doc_id;
    logic [15:0]        tf_count;
    logic signed [15:0] term_idf;
    logic [15:0]        doc_len;
    logic               last_term;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        scored_doc;
    logic signed [31:0] score;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_KNB,
    OP_MUL_KB,
    OP_MUL_TFK,
    OP_MUL_TFAVG,
    OP_MUL_AAVG,
    OP_MUL_BDL,
    OP_MUL_NAVG,
    OP_SETUP,
    OP_DIV,
    OP_MUL_IDF,
    OP_ACC
  } dp_op_t;

  typedef struct packed {
    logic tf_zero;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/bm25s_ctrl.sv
// sequencer for the bm25 scorer: steps the datapath through one item
module bm25s_ctrl
  import bm25s_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_op_t     op
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KNB,
    ST_KB,
    ST_TFK,
    ST_TFAVG,
    ST_AAVG,
    ST_BDL,
    ST_NAVG,
    ST_SETUP,
    ST_DIV,
    ST_IDF,
    ST_ACC
  } state_t;

  localparam int CNT_W = $clog2(Q_W);

  state_t           state;
  logic [CNT_W-1:0] div_cnt;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    case (state)
      ST_IDLE:  op = in_valid ? OP_LOAD : OP_NONE;
      ST_KNB:   op = status.tf_zero ? OP_NONE : OP_MUL_KNB;
      ST_KB:    op = OP_MUL_KB;
      ST_TFK:   op = OP_MUL_TFK;
      ST_TFAVG: op = OP_MUL_TFAVG;
      ST_AAVG:  op = OP_MUL_AAVG;
      ST_BDL:   op = OP_MUL_BDL;
      ST_NAVG:  op = OP_MUL_NAVG;
      ST_SETUP: op = OP_SETUP;
      ST_DIV:   op = OP_DIV;
      ST_IDF:   op = OP_MUL_IDF;
      ST_ACC:   op = (!status.last || status.out_free) ? OP_ACC : OP_NONE;
      default:  op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_KNB;
        end
        // an absent term goes straight to the accumulate step
        ST_KNB:   state <= status.tf_zero ? ST_ACC : ST_KB;
        ST_KB:    state <= ST_TFK;
        ST_TFK:   state <= ST_TFAVG;
        ST_TFAVG: state <= ST_AAVG;
        ST_AAVG:  state <= ST_BDL;
        ST_BDL:   state <= ST_NAVG;
        ST_NAVG:  state <= ST_SETUP;
        ST_SETUP: begin
          state   <= ST_DIV;
          div_cnt <= '0;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(Q_W - 1)) state <= ST_IDF;
        end
        ST_IDF:   state <= ST_ACC;
        ST_ACC: begin
          // hold while a finished score still waits in the output register
          if (!status.last || status.out_free) state <= ST_IDLE;
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> state == ST_KNB)
    else $error("accepted item did not start the sequence");

  a_div_starts_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETUP |=> (state == ST_DIV && div_cnt == '0))
    else $error("divider did not start from step zero");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt != CNT_W'(Q_W - 1)) |=> state == ST_DIV)
    else $error("divider left before all quotient bits");

endmodule

// File: rtl/bm25s_dp.sv
// datapath for the bm25 scorer: config, shared multiplier, divider, total
module bm25s_dp
  import bm25s_pkg::*;
#(
  parameter int SCORE_FRAC_BITS = SCORE_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_op_t                 op,
  output dp_status_t             status,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SHIFT = PRODUCT_FRAC - SCORE_FRAC_BITS;

  logic [15:0] k1;
  logic [16:0] b;
  logic [15:0] avg_len;

  in_item_t in_q;

  logic [MA_W-1:0]          m_knb, m_kb, m_tfk;
  logic [31:0]              p_tfavg;
  logic [NUM_W-1:0]         p_aavg, p_bdl, num;
  logic [DEN_W-1:0]         den, rem;
  logic [Q_W-1:0]           q;
  logic signed [IDFP_W-1:0] prod_idf;
  logic signed [SCORE_W-1:0] running_total;

  logic [16:0]              bb, nb, k1p;
  logic [15:0]              avg_c;
  logic [MA_W-1:0]          mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [DEN_W:0]           shifted;
  logic                     ge;
  logic signed [IDFP_W-1:0] contrib;
  logic signed [IDFP_W:0]   sum;
  logic signed [SCORE_W-1:0] sat;
  logic                     tf_zero;

  assign bb      = (b > B_ONE) ? B_ONE : b;
  assign nb      = B_ONE - bb;
  assign k1p     = {1'b0, k1} + K1_ONE;
  assign avg_c   = (avg_len < AVG_MIN) ? AVG_MIN : avg_len;
  assign tf_zero = (in_q.tf_count == '0);

  // one shared multiplier, operands chosen by the current step
  always_comb begin
    case (op)
      OP_MUL_KNB: begin
        mul_a = MA_W'(k1);
        mul_b = $signed({1'b0, nb});
      end
      OP_MUL_KB: begin
        mul_a = MA_W'(k1);
        mul_b = $signed({1'b0, bb});
      end
      OP_MUL_TFK: begin
        mul_a = MA_W'(in_q.tf_count);
        mul_b = $signed({1'b0, k1p});
      end
      OP_MUL_TFAVG: begin
        mul_a = MA_W'(in_q.tf_count);
        mul_b = $signed({2'b00, avg_c});
      end
      OP_MUL_AAVG: begin
        mul_a = m_knb;
        mul_b = $signed({2'b00, avg_c});
      end
      OP_MUL_BDL: begin
        mul_a = m_kb;
        mul_b = $signed({2'b00, in_q.doc_len});
      end
      OP_MUL_NAVG: begin
        mul_a = m_tfk;
        mul_b = $signed({2'b00, avg_c});
      end
      OP_MUL_IDF: begin
        mul_a = MA_W'(q);
        mul_b = $signed({{2{in_q.term_idf[15]}}, in_q.term_idf});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = $signed({1'b0, mul_a}) * mul_b;

  // restoring step: one quotient bit a cycle
  assign shifted = {rem, 1'b0};
  assign ge      = (shifted >= {1'b0, den});

  // floor to the score format (zero for an absent term), then saturating add
  always_comb begin
    if (tf_zero) begin
      contrib = '0;
    end else begin
      contrib = prod_idf >>> SHIFT;
    end
  end

  assign sum     = {{(IDFP_W + 1 - SCORE_W){running_total[SCORE_W-1]}}, running_total}
                 + {contrib[IDFP_W-1], contrib};

  always_comb begin
    if (!sum[IDFP_W] && (|sum[IDFP_W-1:SCORE_W-1])) begin
      sat = {1'b0, {(SCORE_W-1){1'b1}}};
    end else if (sum[IDFP_W] && !(&sum[IDFP_W-1:SCORE_W-1])) begin
      sat = {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      sat = sum[SCORE_W-1:0];
    end
  end

  assign status.tf_zero  = tf_zero;
  assign status.last     = in_q.last_term;
  assign status.out_free = !out_valid || !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k1      <= K1_RESET;
      b       <= B_RESET;
      avg_len <= AVG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_K1:  k1 <= cfg_data[15:0];
        CFG_B:   b <= cfg_data;
        CFG_AVG: avg_len <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD:      in_q <= in_item;
      OP_MUL_KNB:   m_knb <= prod[MA_W-1:0];
      OP_MUL_KB:    m_kb <= prod[MA_W-1:0];
      OP_MUL_TFK:   m_tfk <= prod[MA_W-1:0];
      OP_MUL_TFAVG: p_tfavg <= prod[31:0];
      OP_MUL_AAVG:  p_aavg <= prod[NUM_W-1:0];
      OP_MUL_BDL:   p_bdl <= prod[NUM_W-1:0];
      OP_MUL_NAVG:  num <= prod[NUM_W-1:0];
      OP_SETUP: begin
        den <= DEN_W'({p_tfavg, {DEN_TF_SHIFT{1'b0}}}) + DEN_W'(p_aavg) + DEN_W'(p_bdl);
        rem <= DEN_W'(num);
        q   <= '0;
      end
      OP_DIV: begin
        rem <= ge ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
        q   <= {q[Q_W-2:0], ge};
      end
      OP_MUL_IDF:   prod_idf <= prod[IDFP_W-1:0];
      default: ;
    endcase
  end

  // running total and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (op == OP_ACC) begin
        running_total <= in_q.last_term ? '0 : sat;
      end
      if (op == OP_ACC && in_q.last_term) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_ACC && in_q.last_term) begin
      out_item.scored_doc <= in_q.doc_id;
      out_item.score      <= sat;
    end
  end

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    op == OP_DIV |-> den != '0)
    else $error("divider running on a zero denominator");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    op == OP_DIV |-> rem < den)
    else $error("partial remainder not below the denominator");

  a_emit_free_slot: assert property (@(posedge clk) disable iff (rst)
    (op == OP_ACC && in_q.last_term) |-> (!out_valid || !out_stall))
    else $error("score written over one not yet taken");

endmodule

// File: rtl/bm25_document_scorer_top.sv
// Okapi BM25 document scorer. Each input item is one query term's posting
// hit; its contribution idf*tf*(k1+1)/(tf+k1*(1-b)+k1*b*dl/avgdl) is added to
// a saturating signed total, and the item marked last_term emits the doc id
// with the total and clears it. An item with a nonzero term frequency runs
// through 7 steps on the one shared multiplier to build numerator and
// denominator, a setup step, the restoring divider (one quotient bit a
// cycle), one multiply by idf and one accumulate, then returns to the idle
// step in which the next item is taken; no new item is accepted before
// that. An absent term (zero term frequency) goes from its first step
// straight to the accumulate step. A last item waits in its accumulate step
// while the output register still holds a score not taken. Configuration
// writes are always ready and must only be made while the block is idle.
module bm25_document_scorer_top
  import bm25s_pkg::*;
#(
  parameter int SCORE_FRAC_BITS = SCORE_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_op_t     op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  bm25s_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  bm25s_dp #(
    .SCORE_FRAC_BITS (SCORE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: sim/bm25_document_scorer_top_tb.sv
// testbench for the bm25 document scorer: directed table then random documents
`timescale 1ns / 1ps

module bm25_document_scorer_top_tb;
  import bm25s_pkg::*;

  localparam int SCORE_FB   = SCORE_FRAC_BITS_DEF;
  localparam int SETTLE     = 60;    // one full term plus margin
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_HITS = 250;

  typedef struct packed {
    logic               is_cfg;
    logic [1:0]         reg_idx;
    logic [16:0]        reg_val;
    in_item_t           hit;
    logic               typed;
    logic signed [31:0] score;
  } dir_row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // scorer state as the block should hold it
  logic [15:0]        k1_r      = K1_RESET;
  logic [16:0]        b_r       = B_RESET;
  logic [15:0]        avg_len_r = AVG_RESET;
  logic signed [31:0] running_score = '0;
  out_item_t          pending_scores[$];

  int  mismatches  = 0;
  int  idle_cycles = 0;
  bit  no_gaps     = 1'b0;

  bm25_document_scorer_top #(.SCORE_FRAC_BITS(SCORE_FB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // contribution of one term in the score format
  function automatic logic signed [63:0] term_gain(in_item_t h);
    logic [63:0]        avg, bw, kk, den, num;
    logic [127:0]       wide_num, ratio;
    logic signed [63:0] idf_w, q_s, prod;
    avg = (avg_len_r < AVG_MIN) ? 64'(AVG_MIN) : 64'(avg_len_r);
    bw  = (b_r > B_ONE) ? 64'(B_ONE) : 64'(b_r);
    kk  = 64'(k1_r);
    if (h.tf_count == 16'd0) return 64'sd0;
    den = ((64'(h.tf_count) << DEN_TF_SHIFT) * avg)
        + kk * (64'(B_ONE) - bw) * avg
        + kk * bw * 64'(h.doc_len);
    if (den == 64'd0) return 64'sd0;
    num = 64'(h.tf_count) * (kk + 64'(K1_ONE)) * avg;
    // ratio in Q.16, denominator carries 2^28 against 2^12 in the numerator
    wide_num = 128'(num) << 32;
    ratio    = wide_num / 128'(den);
    idf_w = h.term_idf;
    q_s   = ratio[63:0];
    prod  = idf_w * q_s;
    return prod >>> (PRODUCT_FRAC - SCORE_FB);
  endfunction

  function automatic void fold_hit(in_item_t h, logic typed, logic signed [31:0] typed_score);
    logic signed [63:0] sum;
    out_item_t          r;
    sum = running_score;
    sum = sum + term_gain(h);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    running_score = sum[31:0];
    if (h.last_term) begin
      r.scored_doc = h.doc_id;
      r.score      = typed ? typed_score : running_score;
      pending_scores = {pending_scores, r};
      running_score = '0;
    end
  endfunction

  task automatic offer_hit(input in_item_t h, input logic typed,
                           input logic signed [31:0] typed_score);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    fold_hit(h, typed, typed_score);
  endtask

  // leaves cfg_valid high so back-to-back writes need no lowering
  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_K1:  k1_r      = val[15:0];
      CFG_B:   b_r       = val;
      CFG_AVG: avg_len_r = val[15:0];
      default: ;
    endcase
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic dir_row_t hit_row(logic [31:0] doc, logic [15:0] tf, logic [15:0] idf,
                                       logic [15:0] dl, logic last, logic typed = 1'b0,
                                       logic [31:0] score = '0);
    dir_row_t r;
    r = '0;
    r.hit.doc_id    = doc;
    r.hit.tf_count  = tf;
    r.hit.term_idf  = idf;
    r.hit.doc_len   = dl;
    r.hit.last_term = last;
    r.typed         = typed;
    r.score         = score;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [16:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic report_miss(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (mismatches < 10)
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        report_miss("unexpected item", out_item.scored_doc, 32'h0);
      end else begin
        want = pending_scores.pop_front();
        if (out_item.scored_doc !== want.scored_doc)
          report_miss("scored_doc", out_item.scored_doc, want.scored_doc);
        if (out_item.score !== want.score)
          report_miss("score", out_item.score, want.score);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("bm25_document_scorer_top_tb: FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, two long hold-offs to back the block up
  initial begin : drain
    int hold;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == 40 || taken == 300) hold = 600;
      else if (no_gaps) hold = 0;
      else hold = $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  initial begin : stimulus
    dir_row_t    dir_rows[$];
    in_item_t    h;
    logic [31:0] doc;
    logic [15:0] k1_v, avg_v;
    logic [16:0] b_v;
    int          sent, nterms, t;
    bit          loud, neg;

    dir_rows = '{
      // reset settings: absent terms then ordinary ones
      hit_row(32'h0, 16'h0, 16'h7FFF, 16'h0, 1'b1, 1'b1, 32'h0),
      hit_row(32'hFFFF_FFFF, 16'h0, 16'h8000, 16'hFFFF, 1'b1, 1'b1, 32'h0),
      hit_row(32'h1, 16'h1, 16'h0100, 16'h1, 1'b1),
      hit_row(32'h2, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b0),
      hit_row(32'h2, 16'hFFFF, 16'h7FFF, 16'h0, 1'b0),
      hit_row(32'h2, 16'h1, 16'h7FFF, 16'hFFFF, 1'b1),
      hit_row(32'h3, 16'h3, 16'h8000, 16'h100, 1'b0),
      hit_row(32'h3, 16'hFFFF, 16'h8000, 16'h0, 1'b0),
      hit_row(32'h3, 16'h0, 16'h8000, 16'h0, 1'b0),
      hit_row(32'h4, 16'h7, 16'hFF00, 16'h9, 1'b1),
      // doc id changes inside one total
      hit_row(32'h5, 16'h2, 16'h0200, 16'h3, 1'b0),
      hit_row(32'h6, 16'h5, 16'h0180, 16'h1, 1'b1),
      // k1 zero, full length weight, zero average: ratio is exactly one
      cfg_row(CFG_K1, 17'h0),
      cfg_row(CFG_B, B_ONE),
      cfg_row(CFG_AVG, 17'h0),
      hit_row(32'h7, 16'h1, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1, 32'h007F_FF00),
      hit_row(32'h8, 16'hFFFF, 16'h8000, 16'h0, 1'b1, 1'b1, 32'hFF80_0000),
      // weight above one, largest k1 and average
      cfg_row(CFG_K1, 17'hFFFF),
      cfg_row(CFG_B, 17'h1FFFF),
      cfg_row(CFG_AVG, 17'hFFFF),
      hit_row(32'h9, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b0),
      hit_row(32'h9, 16'h1, 16'h0001, 16'h0, 1'b1),
      // no length weight
      cfg_row(CFG_B, 17'h0),
      cfg_row(CFG_AVG, 17'h1),
      hit_row(32'hA, 16'h1, 16'h7FFF, 16'hFFFF, 1'b1),
      hit_row(32'hB, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        quiesce();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        offer_hit(dir_rows[i].hit, dir_rows[i].typed, dir_rows[i].score);
      end
    end

    for (int p = 0; p < 8; p++) begin
      quiesce();
      case (p)
        0: begin k1_v = 16'hFFFF; b_v = 17'h0; avg_v = 16'h1; end  // totals saturate
        1: begin k1_v = K1_RESET; b_v = B_RESET; avg_v = 16'($urandom_range(1, 2000)); end
        2: begin k1_v = 16'h0; b_v = B_ONE; avg_v = 16'hFFFF; end
        default: begin
          k1_v  = 16'($urandom_range(0, 65535));
          b_v   = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131071))
                                              : 17'($urandom_range(0, 65536));
          avg_v = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1000))
                                              : 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(CFG_K1, 17'(k1_v));
      write_reg(CFG_B, b_v);
      write_reg(CFG_AVG, 17'(avg_v));
      cfg_valid <= 1'b0;
      no_gaps = (p == 2) || (p == 5);

      sent = 0;
      while (sent < PHASE_HITS) begin
        loud   = ($urandom_range(0, 7) == 0);
        nterms = loud ? $urandom_range(30, 60) : $urandom_range(1, 6);
        neg    = 1'($urandom_range(0, 1));
        doc    = $urandom;
        for (t = 0; t < nterms; t++) begin
          h.doc_id = ($urandom_range(0, 15) == 0) ? 32'($urandom) : doc;
          case ($urandom_range(0, 7))
            0:       h.tf_count = 16'h0;
            1:       h.tf_count = 16'hFFFF;
            2, 3:    h.tf_count = 16'($urandom_range(1, 10));
            default: h.tf_count = 16'($urandom_range(0, 65535));
          endcase
          if (loud) begin
            h.tf_count = 16'($urandom_range(1000, 65535));
            h.term_idf = neg ? 16'($urandom_range(16'h8000, 16'h81FF))
                             : 16'($urandom_range(16'h7E00, 16'h7FFF));
          end else begin
            case ($urandom_range(0, 7))
              0:       h.term_idf = 16'h8000;
              1:       h.term_idf = 16'h7FFF;
              default: h.term_idf = 16'($urandom_range(0, 65535));
            endcase
          end
          case ($urandom_range(0, 5))
            0:       h.doc_len = 16'h0;
            1:       h.doc_len = 16'hFFFF;
            2, 3:    h.doc_len = avg_len_r + 16'($urandom_range(0, 20)) - 16'd10;
            default: h.doc_len = 16'($urandom_range(0, 65535));
          endcase
          h.last_term = (t == nterms - 1);
          offer_hit(h, 1'b0, '0);
          sent++;
        end
      end
    end

    quiesce();
    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("bm25_document_scorer_top_tb: PASS");
    end else begin
      $display("bm25_document_scorer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
